@@ src/rfia_pkg.sv @@
package rfia_pkg;

    // Width of one object index as it travels on the ports and sits in the ring.
    localparam int IndexW = 10;

    // Default ring size.
    localparam int NumObjectsDef = 1024;

    // Request codes.
    localparam logic OpAlloc   = 1'b0;
    localparam logic OpRelease = 1'b1;

    // Result status codes.
    localparam logic [1:0] StOk        = 2'd0;
    localparam logic [1:0] StExhausted = 2'd1;
    localparam logic [1:0] StOverflow  = 2'd2;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    // Memory access strobes from the controller to the ring store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

@@ src/rfia_ring_mem.sv @@
module rfia_ring_mem #(
    parameter int NUM_OBJECTS = rfia_pkg::NumObjectsDef,
    localparam int AW = $clog2(NUM_OBJECTS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rfia_pkg::t_mem_ctl          i_ctl,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [rfia_pkg::IndexW-1:0] i_wr_data,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [rfia_pkg::IndexW-1:0] o_rd_data
);
    import rfia_pkg::*;

    localparam int FW = $clog2(NUM_OBJECTS + 1);
    localparam logic [AW-1:0] LastPos = AW'(NUM_OBJECTS - 1);
    localparam logic [FW-1:0] FillFull = FW'(NUM_OBJECTS);

    logic [IndexW-1:0] r_mem [NUM_OBJECTS];
    logic [IndexW-1:0] r_rd_q;
    logic [AW-1:0]     r_rd_pos;
    logic              r_rd_written;
    logic [FW-1:0]     r_fill;
    logic [FW-1:0]     n_fill;
    logic [AW-1:0]     rd_order;

    // Writes walk the ring in order starting at the last slot, so a slot has
    // been written once the fill count has passed its place in that order.
    assign rd_order = (i_rd_addr == LastPos) ? '0 : i_rd_addr + 1'b1;

    // Fill count saturates once every slot has been written.
    always_comb begin
        n_fill = r_fill;
        if (i_ctl.wr_en && (r_fill != FillFull)) begin
            n_fill = r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // Synchronous ring store, one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_q       <= r_mem[i_rd_addr];
            r_rd_pos     <= i_rd_addr;
            r_rd_written <= (FW'(rd_order) < r_fill);
        end
    end

    // A slot never written reads as its own position.
    assign o_rd_data = r_rd_written ? r_rd_q : IndexW'(r_rd_pos);

endmodule

@@ src/rfia_ctrl.sv @@
module rfia_ctrl #(
    parameter int NUM_OBJECTS = rfia_pkg::NumObjectsDef,
    localparam int AW = $clog2(NUM_OBJECTS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_op,
    input  logic [rfia_pkg::IndexW-1:0] i_index_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rfia_pkg::IndexW-1:0] o_index_out,
    output logic [1:0]                  o_status,
    output rfia_pkg::t_mem_ctl          o_mem_ctl,
    output logic [AW-1:0]               o_wr_addr,
    output logic [rfia_pkg::IndexW-1:0] o_wr_data,
    output logic [AW-1:0]               o_rd_addr,
    input  logic [rfia_pkg::IndexW-1:0] i_rd_data
);
    import rfia_pkg::*;

    localparam logic [AW-1:0] LastPos = AW'(NUM_OBJECTS - 1);

    t_state            r_state;
    t_state            n_state;
    logic [AW-1:0]     r_head;
    logic [AW-1:0]     n_head;
    logic [AW-1:0]     r_tail;
    logic [AW-1:0]     n_tail;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [IndexW-1:0] r_index_out;
    logic [IndexW-1:0] n_index_out;
    logic [1:0]        r_status;
    logic [1:0]        n_status;
    logic              load_out;

    logic [AW-1:0] head_next;
    logic [AW-1:0] tail_next;
    logic          accept;
    logic          alloc_ok;
    logic          rel_ok;

    // Pointer successors with wrap at the last slot.
    assign head_next = (r_head == LastPos) ? '0 : r_head + 1'b1;
    assign tail_next = (r_tail == LastPos) ? '0 : r_tail + 1'b1;

    // A new beat is taken when no read is in flight and the output slot frees up.
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign alloc_ok   = accept && (i_op == OpAlloc) && (head_next != r_tail);
    assign rel_ok     = accept && (i_op == OpRelease) && (tail_next != r_head);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (alloc_ok) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs of the state machine: memory strobes and result register load.
    always_comb begin
        o_mem_ctl   = '0;
        load_out    = 1'b0;
        n_index_out = r_index_out;
        n_status    = r_status;
        unique case (r_state)
            S_IDLE: begin
                o_mem_ctl.rd_en = alloc_ok;
                o_mem_ctl.wr_en = rel_ok;
                if (accept && !alloc_ok) begin
                    load_out    = 1'b1;
                    n_index_out = '0;
                    if (i_op == OpAlloc) begin
                        n_status = StExhausted;
                    end else if (rel_ok) begin
                        n_status = StOk;
                    end else begin
                        n_status = StOverflow;
                    end
                end
            end
            S_READ: begin
                load_out    = 1'b1;
                n_index_out = i_rd_data;
                n_status    = StOk;
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    // Ring addresses and write data.
    assign o_rd_addr = r_head;
    assign o_wr_addr = r_tail;
    assign o_wr_data = i_index_in;

    // Pointer and output valid updates.
    always_comb begin
        n_head      = alloc_ok ? head_next : r_head;
        n_tail      = rel_ok ? tail_next : r_tail;
        n_out_valid = load_out ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= LastPos;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_index_out <= n_index_out;
        r_status    <= n_status;
    end

    assign o_out_valid = r_out_valid;
    assign o_index_out = r_index_out;
    assign o_status    = r_status;

endmodule

@@ src/ring_free_index_allocator.sv @@
// Channel   Valid        Ready        Payload
// request   i_in_valid   o_in_ready   i_op, i_index_in
// result    o_out_valid  i_out_ready  o_index_out, o_status
//
// A release or a refused request loads the result register directly; a successful
// allocate first goes through the registered read of the ring memory at head.
// One request is in work at a time; the result register frees as it is taken.
// Reset is synchronous and needs no clearing pass: a fill count marks which
// ring slots have been written, and unwritten slots read as their own position.
module ring_free_index_allocator #(
    parameter int NUM_OBJECTS = rfia_pkg::NumObjectsDef
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_op,
    input  logic [rfia_pkg::IndexW-1:0] i_index_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rfia_pkg::IndexW-1:0] o_index_out,
    output logic [1:0]                  o_status
);
    import rfia_pkg::*;

    localparam int AW = $clog2(NUM_OBJECTS);

    t_mem_ctl          mem_ctl;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [IndexW-1:0] wr_data;
    logic [IndexW-1:0] rd_data;

    // Request sequencing, pointers and result register.
    rfia_ctrl #(
        .NUM_OBJECTS(NUM_OBJECTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_index_in  (i_index_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_index_out (o_index_out),
        .o_status    (o_status),
        .o_mem_ctl   (mem_ctl),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    // Free index ring.
    rfia_ring_mem #(
        .NUM_OBJECTS(NUM_OBJECTS)
    ) u_ring_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // A read and a write of the ring never share a cycle.
    a_rd_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_ctl.rd_en && mem_ctl.wr_en))
        else $error("ring read and write in the same cycle");

    // While a ring read is in flight no new request is taken.
    a_read_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.rd_en |=> !o_in_ready)
        else $error("request taken during ring read");

    // A ring read turns into a successful result, through the S_READ state and the result register.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.rd_en |-> ##2 (o_out_valid && (o_status == StOk)))
        else $error("ring read did not deliver a successful result");

    // Refused requests always report index zero.
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != StOk)) |-> (o_index_out == '0))
        else $error("refused result carries a nonzero index");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import rfia_pkg::*;

    localparam int RingSize   = NumObjectsDef;
    localparam int IdlePct    = 32;
    localparam int HoldCycles = 150;

    // One expected result beat.
    typedef struct packed {
        logic [IndexW-1:0] index;
        logic [1:0]        status;
    } t_alloc_result;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    logic              i_op        = OpAlloc;
    logic [IndexW-1:0] i_index_in  = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [IndexW-1:0] o_index_out;
    logic [1:0]        o_status;

    // Shadow copy of the free ring and its pointers.
    logic [IndexW-1:0] free_slots [RingSize];
    int unsigned       head_slot;
    int unsigned       tail_slot;

    t_alloc_result expected_q [$];

    int  mismatch_count = 0;
    int  items_sent     = 0;
    int  n_alloc_ok     = 0;
    int  n_exhausted    = 0;
    int  n_release_ok   = 0;
    int  n_overflow     = 0;
    int  n_head_wraps   = 0;
    int  n_tail_wraps   = 0;
    bit  no_idle        = 1'b0;
    bit  hold_req       = 1'b0;

    ring_free_index_allocator #(
        .NUM_OBJECTS(RingSize)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .i_index_in (i_index_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_index_out(o_index_out),
        .o_status   (o_status)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned ring_next(input int unsigned slot);
        return (slot == RingSize - 1) ? 0 : slot + 1;
    endfunction

    // Advances the shadow ring by one request and returns the result it must give.
    function automatic t_alloc_result predict_request(input logic op,
                                                      input logic [IndexW-1:0] idx);
        t_alloc_result res;
        int unsigned   nxt;
        res.index  = '0;
        res.status = StOk;
        if (op == OpAlloc) begin
            nxt = ring_next(head_slot);
            if (nxt == tail_slot) begin
                res.status = StExhausted;
                n_exhausted++;
            end else begin
                res.index = free_slots[head_slot];
                if (nxt == 0) n_head_wraps++;
                head_slot = nxt;
                n_alloc_ok++;
            end
        end else begin
            nxt = ring_next(tail_slot);
            if (nxt == head_slot) begin
                res.status = StOverflow;
                n_overflow++;
            end else begin
                free_slots[tail_slot] = idx;
                if (nxt == 0) n_tail_wraps++;
                tail_slot = nxt;
                n_release_ok++;
            end
        end
        return res;
    endfunction

    // Index values lean toward the extremes now and then.
    function automatic logic [IndexW-1:0] rand_index();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return IndexW'($urandom_range(0, (1 << IndexW) - 1));
    endfunction

    // Offers one request beat and returns at the edge where it is taken.
    task automatic send_request(input logic op, input logic [IndexW-1:0] idx);
        if (!no_idle && $urandom_range(0, 99) < IdlePct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < IdlePct);
        end
        expected_q.push_back(predict_request(op, idx));
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_index_in <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // Compares one result beat with the oldest expectation.
    task automatic check_result();
        t_alloc_result want;
        if (expected_q.size() == 0) begin
            $error("result beat with no request outstanding: index_out %0d status %0d",
                   o_index_out, o_status);
            mismatch_count++;
        end else begin
            want = expected_q.pop_front();
            if (o_index_out !== want.index) begin
                $error("index_out mismatch: expected %0d, actual %0d", want.index, o_index_out);
                mismatch_count++;
            end
            if (o_status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, o_status);
                mismatch_count++;
            end
        end
    endtask

    // Result side: checks taken beats and drives ready, with an occasional long hold.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) check_result();
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (no_idle) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= IdlePct);
            end
        end
    end

    // Releases right after reset find the ring full and overflow.
    task automatic test_release_at_reset();
        send_request(OpRelease, '1);
        send_request(OpRelease, '0);
    endtask

    // The first allocations hand out slots in reset order; index_in is ignored.
    task automatic test_first_allocations();
        send_request(OpAlloc, '1);
        send_request(OpAlloc, '0);
        send_request(OpAlloc, IndexW'(10'h2AA));
    endtask

    // Releases wrap the tail, store duplicates without a check, then overflow again.
    task automatic test_release_wrap_and_duplicates();
        send_request(OpRelease, '1);
        send_request(OpRelease, '0);
        send_request(OpRelease, IndexW'(10'h155));
        send_request(OpRelease, '0);
        send_request(OpAlloc, IndexW'(10'h155));
        send_request(OpRelease, '0);
    endtask

    // Mostly allocations until the ring runs dry, so the head wraps and
    // released values come back out; one stretch runs with no idling.
    task automatic test_fill_to_exhaustion();
        int start_exhausted;
        int count;
        start_exhausted = n_exhausted;
        count = 0;
        while (n_exhausted - start_exhausted < 4 && count < 1500) begin
            no_idle = (count >= 200 && count < 500);
            send_request(($urandom_range(0, 31) == 0) ? OpRelease : OpAlloc, rand_index());
            count++;
        end
        no_idle = 1'b0;
    endtask

    // The result side holds off while requests keep coming, so the input stalls.
    task automatic test_output_hold();
        hold_req = 1'b1;
        repeat (24) send_request(logic'($urandom_range(0, 1)), rand_index());
    endtask

    // Bursts of mostly one kind of request around the exhausted boundary.
    task automatic test_mixed_bursts();
        logic burst_op;
        int   len;
        repeat (10) begin
            burst_op = logic'($urandom_range(0, 1));
            len      = $urandom_range(1, 12);
            repeat (len) begin
                send_request(($urandom_range(0, 3) == 0) ? ~burst_op : burst_op, rand_index());
            end
        end
    endtask

    // Main sequence.
    initial begin
        for (int i = 0; i < RingSize; i++) free_slots[i] = IndexW'(i);
        head_slot = 0;
        tail_slot = RingSize - 1;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_release_at_reset();
        test_first_allocations();
        test_release_wrap_and_duplicates();
        test_fill_to_exhaustion();
        test_output_hold();
        test_mixed_bursts();
        i_in_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d requests: %0d allocations served, %0d refused as exhausted,",
                 items_sent, n_alloc_ok, n_exhausted);
        $display("%0d releases stored, %0d refused as overflow, head wrapped %0d, tail %0d.",
                 n_release_ok, n_overflow, n_head_wraps, n_tail_wraps);
        if (mismatch_count == 0) begin
            $display("ring_free_index_allocator test passed");
        end else begin
            $display("ring_free_index_allocator test failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2ms;
        $display("ring_free_index_allocator test failed");
        $finish;
    end

endmodule

@@ sim.f @@
src/rfia_pkg.sv
src/rfia_ring_mem.sv
src/rfia_ctrl.sv
src/ring_free_index_allocator.sv
tb/testbench.sv
